// ===== hdl/pka_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the protection key allocator.
// No dependencies; imported by protection_key_allocator.
package pka_pkg;

    // Default size of the address space table
    localparam int PKA_TABLE_ENTRIES = 64;

    // Field widths
    localparam int ROOT_W   = 52;
    localparam int MAP_W    = 16;
    localparam int KEYO_W   = 5;
    localparam int KEYI_W   = 6;
    localparam int RIGHTS_W = 32;
    localparam int KIND_W   = 4;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 40;

    // Constants
    localparam logic [KEYO_W-1:0]   NO_KEY      = 5'h1F;
    localparam logic [RIGHTS_W-1:0] EXEC_RIGHTS = 32'h5555_5554;
    localparam logic [MAP_W-1:0]    INIT_MAP    = 16'h0001;
    localparam logic [1:0]          RIGHTS_AD   = 2'b01;
    localparam logic [1:0]          RIGHTS_WD   = 2'b10;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_ALLOC     = 4'd0,
        OP_FREE      = 4'd1,
        OP_IS_ALLOC  = 4'd2,
        OP_XO_KEY    = 4'd3,
        OP_IS_XO     = 4'd4,
        OP_RELEASE   = 4'd5,
        OP_CLONE     = 4'd6,
        OP_ALLOWS    = 4'd7,
        OP_SET_RIGHT = 4'd8,
        OP_EXEC      = 4'd9
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOSPC = 2'd1,
        ST_NOMEM = 2'd2,
        ST_INVAL = 2'd3
    } t_status;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // One table word
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [MAP_W-1:0]  map;
        logic [KEYO_W-1:0] xo;
    } t_entry;

    // Lowest clear key of a map, NO_KEY when all taken
    function automatic logic [KEYO_W-1:0] lowest_clear(input logic [MAP_W-1:0] map);
        logic [KEYO_W-1:0] k;
        k = NO_KEY;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!map[i]) begin
                k = KEYO_W'(i);
            end
        end
        return k;
    endfunction

    // Replace the two rights bits of key k
    function automatic logic [RIGHTS_W-1:0] set_key_rights(input logic [RIGHTS_W-1:0] word,
                                                          input logic [3:0] k,
                                                          input logic [1:0] bits);
        logic [4:0] sh;
        sh = {k, 1'b0};
        return (word & ~(32'h3 << sh)) | ({30'd0, bits} << sh);
    endfunction

endpackage

// ===== hdl/protection_key_allocator.sv =====
`timescale 1ns / 1ps
// Protection key allocator: table of address spaces scanned by one compare stage.
// Table operations pass through S_SCAN, which walks every entry, and S_DRAIN to S_FIN; allows,
// set_rights, is_exec_only with a key below one, unknown kinds and any operation while keys
// are off go from S_IDLE straight to S_FIN. S_FIN waits until the result register is free.
// A new item is taken only in S_IDLE; the root comparator visits one table entry a cycle.
// Reset (synchronous, active low) clears the valid bits, rights word and keys_enabled at once.
module protection_key_allocator
    import pka_pkg::*;
#(
    parameter int TABLE_ENTRIES = PKA_TABLE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: keys_enabled
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: space_root[51:0], target_root[103:52], key[109:104], rights[111:110],
    //        is_write[112], new_rights_word[144:113], zero pad[151:145]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[3:0]
    input  logic [KIND_W-1:0]    s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: status[1:0], key_out[6:2], answer[7], rights_word[39:8]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Control state
    t_state                 r_state;
    logic                   r_keys_en;
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [RIGHTS_W-1:0]    r_tr;
    logic                   r_m_valid;
    logic [M_TDATA_W-1:0]   r_m_data;
    logic [IDX_W-1:0]       r_addr;
    logic [IDX_W-1:0]       r_raddr;
    logic                   r_cmp_v;
    logic                   r_hit, r_thit, r_fre;
    logic [IDX_W-1:0]       r_hidx, r_tidx, r_fidx;
    logic [MAP_W-1:0]       r_smap;
    logic [KEYO_W-1:0]      r_sxo;

    // Latched item
    logic [KIND_W-1:0]      r_kind;
    logic [ROOT_W-1:0]      r_root, r_target;
    logic [KEYI_W-1:0]      r_key;
    logic [1:0]             r_rights;
    logic                   r_wr;
    logic [RIGHTS_W-1:0]    r_new_word;

    // Table memory
    t_entry                 r_tbl_mem [TABLE_ENTRIES];
    t_entry                 r_rd;

    // Input field split
    logic [ROOT_W-1:0]      s_root;
    logic [KEYI_W-1:0]      s_key;
    logic                   s_xfer;
    logic                   need_scan;

    assign s_root = s_axis_tdata[51:0];
    assign s_key  = s_axis_tdata[109:104];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Which operations walk the table
    always_comb begin
        need_scan = 1'b0;
        if (r_keys_en) begin
            case (s_axis_tuser)
                OP_ALLOC, OP_FREE, OP_IS_ALLOC, OP_XO_KEY,
                OP_RELEASE, OP_CLONE, OP_EXEC: need_scan = 1'b1;
                OP_IS_XO: need_scan = !s_key[KEYI_W-1] && (s_key != '0);
                default:  need_scan = 1'b0;
            endcase
        end
    end

    // Commit logic for the finishing cycle
    logic                   commit;
    logic                   c_we;
    logic [IDX_W-1:0]       c_waddr;
    t_entry                 c_wdata;
    logic                   c_vset, c_vclr;
    logic [IDX_W-1:0]       c_vset_idx, c_vclr_idx;
    logic [RIGHTS_W-1:0]    c_tr;
    t_status                c_status;
    logic [KEYO_W-1:0]      c_key_out;
    logic                   c_answer;
    logic [TABLE_ENTRIES-1:0] n_vld;

    assign commit = (r_state == S_FIN) && (!r_m_valid || m_axis_tready);

    always_comb begin
        logic              ent_ok;
        logic [IDX_W-1:0]  eidx;
        logic [MAP_W-1:0]  map;
        logic [KEYO_W-1:0] xo;
        logic [KEYO_W-1:0] lc;
        logic              key_rng;
        logic              key_alloc;
        logic [3:0]        klo;
        logic [3:0]        xk;
        logic [1:0]        bits;
        logic              dest_ok;
        logic [IDX_W-1:0]  dest;

        ent_ok    = (r_root != '0) && (r_hit || r_fre);
        eidx      = r_hit ? r_hidx : r_fidx;
        map       = r_hit ? r_smap : INIT_MAP;
        xo        = r_hit ? r_sxo  : NO_KEY;
        lc        = lowest_clear(map);
        key_rng   = (r_key[KEYI_W-1:4] == 2'b00);
        klo       = r_key[3:0];
        key_alloc = key_rng && (((xo != NO_KEY) && (xo[3:0] == klo) && !xo[4]) || map[klo]);
        xk        = 4'd0;
        bits      = r_tr[{klo, 1'b0} +: 2];
        dest_ok   = r_fre || r_thit;
        dest      = r_fre ? r_fidx : r_tidx;
        if (r_thit && (!r_fre || (r_tidx < r_fidx))) begin
            dest = r_tidx;
        end

        c_we       = 1'b0;
        c_waddr    = eidx;
        c_wdata    = '{root: r_root, map: map, xo: xo};
        c_vset     = 1'b0;
        c_vset_idx = eidx;
        c_vclr     = 1'b0;
        c_vclr_idx = r_hidx;
        c_tr       = r_tr;
        c_status   = ST_OK;
        c_key_out  = NO_KEY;
        c_answer   = 1'b0;

        if (!r_keys_en) begin
            // disabled answers
            case (r_kind)
                OP_ALLOC:  c_status = ST_NOSPC;
                OP_FREE:   c_status = ST_INVAL;
                OP_ALLOWS: c_answer = 1'b1;
                default:   c_status = ST_OK;
            endcase
        end else begin
            case (r_kind)
                OP_ALLOC, OP_FREE, OP_IS_ALLOC, OP_XO_KEY, OP_IS_XO: begin
                    if (r_kind == OP_IS_XO && (r_key[KEYI_W-1] || r_key == '0)) begin
                        c_answer = 1'b0;
                    end else if (!ent_ok) begin
                        c_status = ST_NOMEM;
                    end else begin
                        // entry exists or is claimed now
                        c_we   = 1'b1;
                        c_vset = 1'b1;
                        case (r_kind)
                            OP_ALLOC: begin
                                if (lc == NO_KEY) begin
                                    c_status = ST_NOSPC;
                                end else begin
                                    c_wdata.map = map | (INIT_MAP << lc[3:0]);
                                    c_tr        = set_key_rights(r_tr, lc[3:0], r_rights);
                                    c_key_out   = lc;
                                end
                            end
                            OP_FREE: begin
                                if (key_alloc) begin
                                    c_wdata.map = map & ~(INIT_MAP << klo);
                                end else begin
                                    c_status = ST_INVAL;
                                end
                            end
                            OP_IS_ALLOC: c_answer = key_alloc;
                            OP_XO_KEY: begin
                                if (xo == NO_KEY) begin
                                    if (lc == NO_KEY) begin
                                        c_status = ST_NOSPC;
                                    end else begin
                                        c_wdata.map = map | (INIT_MAP << lc[3:0]);
                                        c_wdata.xo  = lc;
                                        c_tr = set_key_rights(r_tr, lc[3:0], RIGHTS_AD);
                                        c_key_out   = lc;
                                    end
                                end else begin
                                    xk = xo[3:0];
                                    if (!r_tr[{xk, 1'b0}]) begin
                                        c_tr = set_key_rights(r_tr, xk, RIGHTS_AD);
                                    end
                                    c_key_out = {1'b0, xk};
                                end
                            end
                            default: c_answer = (xo != NO_KEY) && ({1'b0, xo} == r_key);
                        endcase
                    end
                end
                OP_RELEASE, OP_EXEC: begin
                    c_vclr = (r_root != '0) && r_hit;
                    if (r_kind == OP_EXEC) begin
                        c_tr = EXEC_RIGHTS;
                    end
                end
                OP_CLONE: begin
                    if (r_root != '0 && r_target != '0) begin
                        c_vclr     = r_thit;
                        c_vclr_idx = r_tidx;
                        if (r_hit) begin
                            if (dest_ok) begin
                                c_we       = 1'b1;
                                c_waddr    = dest;
                                c_wdata    = '{root: r_target, map: r_smap, xo: r_sxo};
                                c_vset     = 1'b1;
                                c_vset_idx = dest;
                            end else begin
                                c_status = ST_NOMEM;
                            end
                        end
                    end
                end
                OP_ALLOWS: begin
                    if (!key_rng) begin
                        c_status = ST_INVAL;
                    end else if (bits[0]) begin
                        c_answer = 1'b0;
                    end else begin
                        c_answer = !(r_wr && bits[1]);
                    end
                end
                OP_SET_RIGHT: c_tr = r_new_word;
                default:      c_status = ST_OK;
            endcase
        end
    end

    // Valid bits after the finishing cycle; a set wins over a clear of the same entry
    always_comb begin
        n_vld = r_vld;
        if (c_vclr) begin
            n_vld[c_vclr_idx] = 1'b0;
        end
        if (c_vset) begin
            n_vld[c_vset_idx] = 1'b1;
        end
    end

    // Sequencer, scan comparator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_keys_en <= 1'b0;
            r_vld     <= '0;
            r_tr      <= '0;
            r_m_valid <= 1'b0;
            r_addr    <= '0;
            r_cmp_v   <= 1'b0;
            r_hit     <= 1'b0;
            r_thit    <= 1'b0;
            r_fre     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keys_en <= i_cfg_wdata;
            end
            // result valid: set on commit, dropped by a result transfer
            if (commit) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            // compare stage for the entry read last cycle
            r_cmp_v <= (r_state == S_SCAN);
            r_raddr <= r_addr;
            if (r_cmp_v) begin
                if (r_vld[r_raddr] && (r_rd.root == r_root) && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_raddr;
                    r_smap <= r_rd.map;
                    r_sxo  <= r_rd.xo;
                end
                if (r_vld[r_raddr] && (r_rd.root == r_target) && !r_thit) begin
                    r_thit <= 1'b1;
                    r_tidx <= r_raddr;
                end
                if (!r_vld[r_raddr] && !r_fre) begin
                    r_fre  <= 1'b1;
                    r_fidx <= r_raddr;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_hit   <= 1'b0;
                        r_thit  <= 1'b0;
                        r_fre   <= 1'b0;
                        r_addr  <= '0;
                        r_state <= need_scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_FIN;
                S_FIN: begin
                    if (commit) begin
                        r_m_data  <= {(r_keys_en ? c_tr : 32'd0), c_answer, c_key_out, c_status};
                        r_tr      <= c_tr;
                        r_vld     <= n_vld;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item capture on input transfer
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_kind     <= s_axis_tuser;
            r_root     <= s_root;
            r_target   <= s_axis_tdata[103:52];
            r_key      <= s_key;
            r_rights   <= s_axis_tdata[111:110];
            r_wr       <= s_axis_tdata[112];
            r_new_word <= s_axis_tdata[144:113];
        end
    end

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (commit && c_we) begin
            r_tbl_mem[c_waddr] <= c_wdata;
        end
        r_rd <= r_tbl_mem[r_addr];
    end

endmodule

// ===== tb/protection_key_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for protection_key_allocator: directed and random requests
// on the input stream, results checked against an in-bench model of the key table.
// Depends on pka_pkg and hdl/protection_key_allocator.sv.
module protection_key_allocator_tb
    import pka_pkg::*;
();

    localparam int TBL              = PKA_TABLE_ENTRIES;
    localparam int KEY_COUNT        = MAP_W;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = TBL + 8;
    localparam int POOL_SIZE        = 6;
    localparam int FIRST_SPARE_KIND = int'(OP_EXEC) + 1;
    localparam int LAST_SPARE_KIND  = (1 << KIND_W) - 1;
    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

    // One request as it travels on the input stream
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [ROOT_W-1:0]   root;
        logic [ROOT_W-1:0]   target;
        logic [KEYI_W-1:0]   key;
        logic [1:0]          rights;
        logic                is_write;
        logic [RIGHTS_W-1:0] word;
    } t_request;

    // One result as it travels on the output stream
    typedef struct {
        logic [1:0]          status;
        logic [KEYO_W-1:0]   key_out;
        logic                answer;
        logic [RIGHTS_W-1:0] rights_word;
    } t_outcome;

    // Ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: space_root, target_root, key, rights, is_write, new_rights_word, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: kind
    logic [KIND_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: status, key_out, answer, rights_word
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Stimulus and scoreboard
    t_request          pending_reqs[$];
    t_outcome          expected_outcomes[$];
    logic [ROOT_W-1:0] root_pool[POOL_SIZE];
    logic [ROOT_W-1:0] seen_roots[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_off      = 1'b0;
    logic              in_fire       = 1'b0;
    int                error_count   = 0;
    int                items_in      = 0;
    int                results_seen  = 0;
    int                nomem_seen    = 0;
    int                nospc_seen    = 0;
    int                queued        = 0;

    // Model of the key table
    logic [ROOT_W-1:0]   space_root_tbl[TBL];
    logic [MAP_W-1:0]    key_map_tbl[TBL];
    logic [KEYO_W-1:0]   xo_key_tbl[TBL];
    logic [RIGHTS_W-1:0] thread_word;
    logic                keys_on;

    protection_key_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int slot_of(input logic [ROOT_W-1:0] root);
        for (int i = 0; i < TBL; i++) begin
            if (space_root_tbl[i] == root) return i;
        end
        return -1;
    endfunction

    // Look up a space, claiming the lowest free slot for an unknown root
    function automatic int claim_slot(input logic [ROOT_W-1:0] root);
        int i;
        if (root == '0) return -1;
        i = slot_of(root);
        if (i >= 0) return i;
        i = slot_of('0);
        if (i >= 0) begin
            space_root_tbl[i] = root;
            key_map_tbl[i]    = INIT_MAP;
            xo_key_tbl[i]     = NO_KEY;
        end
        return i;
    endfunction

    function automatic void drop_space(input logic [ROOT_W-1:0] root);
        int i;
        if (root == '0) return;
        i = slot_of(root);
        if (i >= 0) begin
            space_root_tbl[i] = '0;
            key_map_tbl[i]    = '0;
            xo_key_tbl[i]     = NO_KEY;
        end
    endfunction

    function automatic int free_key_of(input logic [MAP_W-1:0] map);
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!map[k]) return k;
        end
        return -1;
    endfunction

    function automatic void set_rights_bits(input int k, input logic [1:0] bits);
        thread_word = (thread_word & ~(32'h3 << (2 * k))) | (32'(bits) << (2 * k));
    endfunction

    // Allocated in the map, or the execute-only key even when freed
    function automatic bit key_held(input int e, input int k);
        if (k < 0 || k >= KEY_COUNT) return 1'b0;
        if (xo_key_tbl[e] != NO_KEY && int'(xo_key_tbl[e]) == k) return 1'b1;
        return key_map_tbl[e][k];
    endfunction

    // Apply one request to the model and return the result it should give
    function automatic t_outcome predict_outcome(input t_request rq);
        t_outcome         o;
        int               key;
        int               e;
        int               k;
        bit               fresh;
        logic [MAP_W-1:0] map_copy;
        logic [KEYO_W-1:0] xo_copy;
        logic [1:0]       bits;
        key       = int'($signed(rq.key));
        o.status  = ST_OK;
        o.key_out = NO_KEY;
        o.answer  = 1'b0;
        case (rq.kind)
            OP_ALLOC: begin
                if (!keys_on) begin
                    o.status = ST_NOSPC;
                end else begin
                    e = claim_slot(rq.root);
                    if (e < 0) begin
                        o.status = ST_NOMEM;
                    end else begin
                        k = free_key_of(key_map_tbl[e]);
                        if (k < 0) begin
                            o.status = ST_NOSPC;
                        end else begin
                            key_map_tbl[e][k] = 1'b1;
                            set_rights_bits(k, rq.rights);
                            o.key_out = KEYO_W'(k);
                        end
                    end
                end
            end
            OP_FREE: begin
                if (!keys_on) begin
                    o.status = ST_INVAL;
                end else begin
                    e = claim_slot(rq.root);
                    if (e < 0) o.status = ST_NOMEM;
                    else if (key_held(e, key)) key_map_tbl[e][key] = 1'b0;
                    else o.status = ST_INVAL;
                end
            end
            OP_IS_ALLOC: begin
                if (keys_on) begin
                    e = claim_slot(rq.root);
                    if (e < 0) o.status = ST_NOMEM;
                    else o.answer = key_held(e, key);
                end
            end
            OP_XO_KEY: begin
                if (keys_on) begin
                    e = claim_slot(rq.root);
                    if (e < 0) begin
                        o.status = ST_NOMEM;
                    end else begin
                        fresh = 1'b0;
                        if (xo_key_tbl[e] == NO_KEY) begin
                            k = free_key_of(key_map_tbl[e]);
                            if (k >= 0) begin
                                key_map_tbl[e][k] = 1'b1;
                                xo_key_tbl[e]     = KEYO_W'(k);
                                fresh             = 1'b1;
                            end
                        end else begin
                            k = int'(xo_key_tbl[e][3:0]);
                        end
                        if (k < 0) begin
                            o.status = ST_NOSPC;
                        end else begin
                            // access-disable only, unless the key already has it
                            if (fresh || !thread_word[2 * k]) set_rights_bits(k, RIGHTS_AD);
                            o.key_out = KEYO_W'(k);
                        end
                    end
                end
            end
            OP_IS_XO: begin
                if (keys_on && key > 0) begin
                    e = claim_slot(rq.root);
                    if (e < 0) o.status = ST_NOMEM;
                    else o.answer = xo_key_tbl[e] != NO_KEY && int'(xo_key_tbl[e]) == key;
                end
            end
            OP_RELEASE: begin
                if (keys_on) drop_space(rq.root);
            end
            OP_CLONE: begin
                if (keys_on && rq.root != '0 && rq.target != '0) begin
                    e        = slot_of(rq.root);
                    map_copy = (e >= 0) ? key_map_tbl[e] : '0;
                    xo_copy  = (e >= 0) ? xo_key_tbl[e] : NO_KEY;
                    // target goes first; an unknown source leaves it released
                    drop_space(rq.target);
                    if (e >= 0) begin
                        e = claim_slot(rq.target);
                        if (e < 0) begin
                            o.status = ST_NOMEM;
                        end else begin
                            key_map_tbl[e] = map_copy;
                            xo_key_tbl[e]  = xo_copy;
                        end
                    end
                end
            end
            OP_ALLOWS: begin
                if (!keys_on) begin
                    o.answer = 1'b1;
                end else if (key < 0 || key >= KEY_COUNT) begin
                    o.status = ST_INVAL;
                end else begin
                    bits     = thread_word[2 * key +: 2];
                    o.answer = !bits[0] && !(rq.is_write && bits[1]);
                end
            end
            OP_SET_RIGHT: begin
                if (keys_on) thread_word = rq.word;
            end
            OP_EXEC: begin
                if (keys_on) begin
                    drop_space(rq.root);
                    thread_word = EXEC_RIGHTS;
                end
            end
            default: ;
        endcase
        o.rights_word = keys_on ? thread_word : '0;
        return o;
    endfunction

    // ------------------------------------------------------------ stimulus

    function automatic void queue_op(input t_request rq);
        pending_reqs.push_back(rq);
        queued++;
    endfunction

    function automatic void add_op(input logic [KIND_W-1:0] kind,
                                   input logic [ROOT_W-1:0] root,
                                   input logic [ROOT_W-1:0] target,
                                   input int key, input int rights, input bit wr,
                                   input logic [RIGHTS_W-1:0] word);
        t_request rq;
        rq.kind     = kind;
        rq.root     = root;
        rq.target   = target;
        rq.key      = KEYI_W'(key);
        rq.rights   = 2'(rights);
        rq.is_write = wr;
        rq.word     = word;
        queue_op(rq);
    endfunction

    // A random nonzero root; remembered so later requests can hit it
    function automatic logic [ROOT_W-1:0] fresh_root();
        logic [ROOT_W-1:0] r;
        r = ROOT_W'({$urandom(), $urandom()});
        if (r == '0) r = ROOT_MAX;
        seen_roots.push_back(r);
        return r;
    endfunction

    function automatic logic [ROOT_W-1:0] pick_root();
        int r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 60) return root_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 82 && seen_roots.size() != 0)
            return seen_roots[$urandom_range(seen_roots.size() - 1)];
        return fresh_root();
    endfunction

    // Mostly -1..16, sometimes any 6-bit pattern
    function automatic logic [KEYI_W-1:0] pick_key();
        if ($urandom_range(99) < 85) return KEYI_W'($urandom_range(17) - 1);
        return KEYI_W'($urandom());
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        int r;
        r = $urandom_range(99);
        if (r < 16) return OP_ALLOC;
        if (r < 28) return OP_FREE;
        if (r < 37) return OP_IS_ALLOC;
        if (r < 47) return OP_XO_KEY;
        if (r < 55) return OP_IS_XO;
        if (r < 60) return OP_RELEASE;
        if (r < 69) return OP_CLONE;
        if (r < 82) return OP_ALLOWS;
        if (r < 88) return OP_SET_RIGHT;
        if (r < 92) return OP_EXEC;
        return KIND_W'($urandom_range(LAST_SPARE_KIND, FIRST_SPARE_KIND));
    endfunction

    function automatic t_request random_request(input logic [KIND_W-1:0] kind);
        t_request rq;
        int       w;
        rq.kind     = kind;
        rq.root     = pick_root();
        rq.target   = (kind == OP_CLONE) ? pick_root() : ROOT_W'({$urandom(), $urandom()});
        rq.key      = pick_key();
        rq.rights   = 2'($urandom_range(3));
        rq.is_write = 1'($urandom_range(1));
        w           = $urandom_range(9);
        rq.word     = (w == 0) ? '0 : (w == 1) ? '1 : (w == 2) ? EXEC_RIGHTS : $urandom();
        return rq;
    endfunction

    function automatic void queue_random(input int n);
        int                goal;
        t_request          rq;
        logic [ROOT_W-1:0] r;
        goal = queued + n;
        while (queued < goal) begin
            if ($urandom_range(999) < 15) begin
                // run one space out of keys, then ask for an execute-only key and free some
                r = root_pool[$urandom_range(POOL_SIZE - 1)];
                repeat (KEY_COUNT + 1) begin
                    rq      = random_request(OP_ALLOC);
                    rq.root = r;
                    queue_op(rq);
                end
                rq      = random_request(OP_XO_KEY);
                rq.root = r;
                queue_op(rq);
                repeat (3) begin
                    rq      = random_request(OP_FREE);
                    rq.root = r;
                    queue_op(rq);
                end
            end else begin
                queue_op(random_request(random_kind()));
            end
        end
    endfunction

    // Claim more spaces than the table holds, then give a few back
    function automatic void fill_table();
        t_request rq;
        repeat (TBL + 2) begin
            rq      = random_request(OP_ALLOC);
            rq.root = fresh_root();
            queue_op(rq);
        end
        repeat (8) begin
            rq      = random_request(OP_RELEASE);
            rq.root = seen_roots[$urandom_range(seen_roots.size() - 1)];
            queue_op(rq);
        end
    endfunction

    task automatic write_keys_enabled(input logic value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Wait until every queued request has gone in and its result has come back
    task automatic wait_quiet();
        while (items_in != queued || results_seen != items_in)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------ drivers

    // Input side: next request after each transfer, with random gaps
    always @(negedge i_clk) begin : drive_requests
        t_request nxt;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt           = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.kind;
                s_axis_tdata  <= S_TDATA_W'({nxt.word, nxt.is_write, nxt.rights, nxt.key,
                                             nxt.target, nxt.root});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure plus the long hold-off
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------ checking

    task automatic check_field(input string what, input logic [RIGHTS_W-1:0] want,
                               input logic [RIGHTS_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                     $time, results_seen, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_request rq;
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL; i++) begin
                space_root_tbl[i] = '0;
                key_map_tbl[i]    = '0;
                xo_key_tbl[i]     = NO_KEY;
            end
            thread_word = '0;
            keys_on     = 1'b0;
            in_fire     <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_we) keys_on = i_cfg_wdata;
            // result transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("status", RIGHTS_W'(want.status), RIGHTS_W'(m_axis_tdata[1:0]));
                    check_field("key_out", RIGHTS_W'(want.key_out), RIGHTS_W'(m_axis_tdata[6:2]));
                    check_field("answer", RIGHTS_W'(want.answer), RIGHTS_W'(m_axis_tdata[7]));
                    check_field("rights_word", want.rights_word, m_axis_tdata[39:8]);
                end
            end
            // request transfer: predict from what was actually driven
            if (s_axis_tvalid && s_axis_tready) begin
                rq.kind     = s_axis_tuser;
                rq.root     = s_axis_tdata[51:0];
                rq.target   = s_axis_tdata[103:52];
                rq.key      = s_axis_tdata[109:104];
                rq.rights   = s_axis_tdata[111:110];
                rq.is_write = s_axis_tdata[112];
                rq.word     = s_axis_tdata[144:113];
                want        = predict_outcome(rq);
                if (want.status == ST_NOMEM) nomem_seen++;
                if (want.status == ST_NOSPC) nospc_seen++;
                expected_outcomes.push_back(want);
                items_in++;
            end
        end
    end

    // ------------------------------------------------------------ sequence

    initial begin : run_test
        root_pool[0] = 52'd1;
        root_pool[1] = ROOT_MAX;
        root_pool[2] = 52'h8_0000_0000_0000;
        for (int i = 3; i < POOL_SIZE; i++) root_pool[i] = fresh_root();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // keys off: alloc, free, xo_key, allows, is_alloc and a spare kind take their disabled answers
        write_keys_enabled(1'b0);
        add_op(OP_ALLOC, 52'd1, '0, 0, 3, 1'b0, '0);
        add_op(OP_FREE, 52'd1, '0, 0, 0, 1'b0, '0);
        add_op(OP_XO_KEY, ROOT_MAX, '0, 0, 0, 1'b0, '0);
        add_op(OP_ALLOWS, 52'd1, '0, -1, 0, 1'b1, '0);
        add_op(OP_IS_ALLOC, 52'd1, '0, 0, 0, 1'b0, '0);
        add_op(KIND_W'(LAST_SPARE_KIND), ROOT_MAX, ROOT_MAX, 31, 3, 1'b1, '1);
        wait_quiet();

        // keys on: directed corners
        write_keys_enabled(1'b1);
        add_op(OP_ALLOC, ROOT_MAX, '0, 0, 3, 1'b0, '0);
        add_op(OP_ALLOC, '0, '0, 0, 1, 1'b0, '0);
        add_op(OP_FREE, ROOT_MAX, '0, -32, 0, 1'b0, '0);
        add_op(OP_FREE, ROOT_MAX, '0, 16, 0, 1'b0, '0);
        add_op(OP_XO_KEY, ROOT_MAX, '0, 0, 0, 1'b0, '0);
        add_op(OP_IS_XO, ROOT_MAX, '0, 2, 0, 1'b0, '0);
        add_op(OP_IS_XO, ROOT_MAX, '0, 0, 0, 1'b0, '0);
        add_op(OP_FREE, ROOT_MAX, '0, 2, 0, 1'b0, '0);
        add_op(OP_IS_ALLOC, ROOT_MAX, '0, 2, 0, 1'b0, '0);
        add_op(OP_FREE, ROOT_MAX, '0, 0, 0, 1'b0, '0);
        add_op(OP_IS_ALLOC, 52'd1, '0, 0, 0, 1'b0, '0);
        add_op(OP_ALLOWS, ROOT_MAX, '0, 1, 0, 1'b1, '0);
        add_op(OP_ALLOWS, ROOT_MAX, '0, 31, 0, 1'b0, '0);
        add_op(OP_SET_RIGHT, '0, '0, 0, 0, 1'b0, '1);
        add_op(OP_ALLOWS, ROOT_MAX, '0, 15, 0, 1'b0, '0);
        add_op(OP_CLONE, ROOT_MAX, 52'd1, 0, 0, 1'b0, '0);
        add_op(OP_CLONE, '0, 52'd1, 0, 0, 1'b0, '0);
        add_op(OP_CLONE, 52'h123, 52'd1, 0, 0, 1'b0, '0);
        add_op(OP_SET_RIGHT, '0, '0, 0, 0, 1'b0, '0);
        add_op(OP_EXEC, ROOT_MAX, '0, 0, 0, 1'b0, '0);
        add_op(OP_RELEASE, '0, '0, 0, 0, 1'b0, '0);
        add_op(KIND_W'(FIRST_SPARE_KIND), '0, '0, 0, 0, 1'b0, '0);
        wait_quiet();

        // sender idles little, receiver much
        send_idle_pct = 29;
        recv_idle_pct = 74;
        queue_random(230);
        wait_quiet();

        // a short stretch with keys off; the table must survive it
        write_keys_enabled(1'b0);
        queue_random(25);
        wait_quiet();
        write_keys_enabled(1'b1);

        // roles swapped, with the table driven full
        send_idle_pct = 74;
        recv_idle_pct = 29;
        fill_table();
        queue_random(200);
        wait_quiet();

        // no idling; the receiver holds off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        wait_quiet();

        $display("Ran %0d requests with keys on and off, %0d results checked,",
                 items_in, results_seen);
        $display("including %0d table-full and %0d out-of-keys answers.",
                 nomem_seen, nospc_seen);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("%0t: run limit reached", $time);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pka_pkg.sv
hdl/protection_key_allocator.sv
tb/protection_key_allocator_tb.sv
